/* hw/rtl/sgbe_pkg.sv */
// ----------------------------------------------------------------------------
// sgbe_pkg
// Shared types and constants for the scaled glyph bitmap expander.
// ----------------------------------------------------------------------------
package sgbe_pkg;

  localparam int CoordW  = 18;
  localparam int QDepth  = 4;
  localparam int QAddrW  = 2;
  localparam int QCountW = 3;

  localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd2;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd3;
  localparam logic [2:0] REG_SCALE        = 3'd4;
  localparam logic [2:0] REG_DRAW_COLOR   = 3'd5;

  localparam logic [7:0] LEFT_PIXEL = 8'h80;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic [7:0]         glyph_width;
    logic [7:0]         glyph_height;
    logic [7:0]         scale;
    logic [15:0]        draw_color;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  mask;
    coord_t      base_x;
    coord_t      y;
    logic [7:0]  size;
    logic [15:0] color;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic coord_t widen16(logic signed [15:0] v);
    return {{2{v[15]}}, v};
  endfunction

endpackage

/* hw/rtl/sgbe_front.sv */
// ----------------------------------------------------------------------------
// sgbe_front
// Accepts bitmap bytes, tracks glyph position and queues pixel masks.
// ----------------------------------------------------------------------------
module sgbe_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sgbe_pkg::cfg_t       cfg,
  input  logic                 accept,
  input  logic [7:0]           glyph_bits,
  input  logic                 first_byte,
  output logic                 q_push,
  output sgbe_pkg::entry_t     q_data
);

  logic [4:0]       byte_in_row_r, byte_in_row_nxt;
  logic [7:0]       row_index_r, row_index_nxt;
  sgbe_pkg::coord_t row_top_y_r, row_top_y_nxt;
  sgbe_pkg::coord_t byte_left_x_r, byte_left_x_nxt;

  logic [4:0]       eff_bir;
  logic [7:0]       eff_row;
  sgbe_pkg::coord_t eff_y;
  sgbe_pkg::coord_t eff_x;
  logic             in_glyph;
  logic [5:0]       bytes_per_row;
  logic [8:0]       width_round;
  logic             row_end;
  logic [7:0]       mask;

  always_comb begin
    eff_bir     = first_byte ? 5'd0 : byte_in_row_r;
    eff_row     = first_byte ? 8'd0 : row_index_r;
    eff_y       = first_byte ? sgbe_pkg::widen16(cfg.origin_y) : row_top_y_r;
    eff_x       = first_byte ? sgbe_pkg::widen16(cfg.origin_x) : byte_left_x_r;
    in_glyph    = eff_row < cfg.glyph_height;
    width_round = {1'b0, cfg.glyph_width} + 9'd7;
    bytes_per_row = (width_round[8:3] == 6'd0) ? 6'd1 : width_round[8:3];
    row_end     = ({1'b0, eff_bir} + 6'd1) >= bytes_per_row;
    for (int b = 0; b < 8; b++) begin
      mask[7-b] = glyph_bits[7-b] & ({eff_bir, 3'(b)} < cfg.glyph_width);
    end
  end

  always_comb begin
    byte_in_row_nxt = byte_in_row_r;
    row_index_nxt   = row_index_r;
    row_top_y_nxt   = row_top_y_r;
    byte_left_x_nxt = byte_left_x_r;
    if (accept) begin
      byte_in_row_nxt = eff_bir;
      row_index_nxt   = eff_row;
      row_top_y_nxt   = eff_y;
      byte_left_x_nxt = eff_x;
      if (in_glyph) begin
        if (row_end) begin
          byte_in_row_nxt = 5'd0;
          row_index_nxt   = eff_row + 8'd1;
          row_top_y_nxt   = sgbe_pkg::CoordW'(eff_y + {10'd0, cfg.scale});
          byte_left_x_nxt = sgbe_pkg::widen16(cfg.origin_x);
        end else begin
          byte_in_row_nxt = eff_bir + 5'd1;
          byte_left_x_nxt = sgbe_pkg::CoordW'(eff_x + {7'd0, cfg.scale, 3'b000});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_in_row_r <= 5'd0;
      row_index_r   <= 8'd0;
      row_top_y_r   <= '0;
      byte_left_x_r <= '0;
    end else begin
      byte_in_row_r <= byte_in_row_nxt;
      row_index_r   <= row_index_nxt;
      row_top_y_r   <= row_top_y_nxt;
      byte_left_x_r <= byte_left_x_nxt;
    end
  end

  assign q_push        = accept && in_glyph && (mask != 8'h00);
  assign q_data.mask   = mask;
  assign q_data.base_x = eff_x;
  assign q_data.y      = eff_y;
  assign q_data.size   = cfg.scale;
  assign q_data.color  = cfg.draw_color;

endmodule

/* hw/rtl/sgbe_queue.sv */
// ----------------------------------------------------------------------------
// sgbe_queue
// Short queue of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module sgbe_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sgbe_pkg::entry_t      push_data,
  input  logic                  pop,
  output sgbe_pkg::entry_t      head,
  output sgbe_pkg::q_status_t   status
);

  sgbe_pkg::entry_t                 mem_r [sgbe_pkg::QDepth];
  logic [sgbe_pkg::QAddrW-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [sgbe_pkg::QAddrW-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [sgbe_pkg::QCountW-1:0]     count_r, count_nxt;
  logic                             do_push;
  logic                             do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == sgbe_pkg::QCountW'(sgbe_pkg::QDepth));
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hw/rtl/sgbe_back.sv */
// ----------------------------------------------------------------------------
// sgbe_back
// Walks the set pixels of each queued byte and emits one fill per cycle while the result port is not stalled.
// ----------------------------------------------------------------------------
module sgbe_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sgbe_pkg::entry_t     q_head,
  input  sgbe_pkg::q_status_t  q_status,
  output logic                 q_pop,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic signed [17:0]   out_fill_x,
  output logic signed [17:0]   out_fill_y,
  output logic [7:0]           out_fill_size,
  output logic [15:0]          out_fill_color,
  output logic                 out_last_of_byte
);

  sgbe_pkg::entry_t cur_r, cur_nxt;
  logic             cur_valid_r, cur_valid_nxt;
  logic             out_valid_r, out_valid_nxt;
  sgbe_pkg::coord_t fill_x_r, fill_y_r;
  logic [7:0]       size_r;
  logic [15:0]      color_r;
  logic             last_r;

  logic             adv;
  logic             emit;
  logic             load;
  logic [2:0]       pix;
  logic             found;
  logic [7:0]       rest;
  logic             last;
  logic [10:0]      offset;
  sgbe_pkg::coord_t pix_x;

  always_comb begin
    pix   = 3'd0;
    found = 1'b0;
    for (int b = 0; b < 8; b++) begin
      if (!found && cur_r.mask[7-b]) begin
        pix   = 3'(b);
        found = 1'b1;
      end
    end
    rest   = cur_r.mask & ~(sgbe_pkg::LEFT_PIXEL >> pix);
    last   = (rest == 8'h00);
    offset = 11'(pix) * 11'(cur_r.size);
    pix_x  = sgbe_pkg::CoordW'(cur_r.base_x + {7'd0, offset});
  end

  assign adv   = !out_valid_r || out_pop;
  assign emit  = cur_valid_r && adv;
  assign load  = !q_status.empty && (!cur_valid_r || (emit && last));
  assign q_pop = load;

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (emit) begin
      cur_nxt.mask = rest;
      if (last) begin
        cur_valid_nxt = 1'b0;
      end
    end
    if (load) begin
      cur_nxt       = q_head;
      cur_valid_nxt = 1'b1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) begin
      fill_x_r <= pix_x;
      fill_y_r <= cur_r.y;
      size_r   <= cur_r.size;
      color_r  <= cur_r.color;
      last_r   <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_fill_x       = fill_x_r;
  assign out_fill_y       = fill_y_r;
  assign out_fill_size    = size_r;
  assign out_fill_color   = color_r;
  assign out_last_of_byte = last_r;

endmodule

/* hw/rtl/scaled_glyph_bitmap_expander_unit.sv */
// ----------------------------------------------------------------------------
// scaled_glyph_bitmap_expander_unit
// Expands 1-bpp glyph bytes into scaled square fill commands.
//
//   channel   ports                                   transfer when
//   input     in_glyph_bits, in_first_byte            in_push & !in_full
//   result    out_fill_x/y/size/color, out_last_of_byte  out_pop & !out_empty
//   config    cfg_wr_en, cfg_index, cfg_wdata         cfg_wr_en
//
// One command leaves per cycle while the result port is not stalled; the back
// part emits one command per set pixel, a byte with none stops in the front part.
// A four-entry queue between front and back absorbs bursts of bytes.
// A byte's first result is registered in the queue, then in the back part's current-byte register, then at the output.
// rst_n is synchronous; it clears position state, queue and output stage and restores the register defaults.
// in_full rises when four bytes wait, behind a stalled result port or fed
// faster than their pixels leave.
// ----------------------------------------------------------------------------
module scaled_glyph_bitmap_expander_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [7:0]          in_glyph_bits,
  input  logic                in_first_byte,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [17:0]  out_fill_x,
  output logic signed [17:0]  out_fill_y,
  output logic [7:0]          out_fill_size,
  output logic [15:0]         out_fill_color,
  output logic                out_last_of_byte,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);

  sgbe_pkg::cfg_t      cfg_r;
  sgbe_pkg::entry_t    q_push_data;
  sgbe_pkg::entry_t    q_head;
  sgbe_pkg::q_status_t q_status;
  logic                q_push;
  logic                q_pop;
  logic                accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= 16'sd0;
      cfg_r.origin_y     <= 16'sd0;
      cfg_r.glyph_width  <= 8'd8;
      cfg_r.glyph_height <= 8'd8;
      cfg_r.scale        <= 8'd1;
      cfg_r.draw_color   <= 16'hFFFF;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        sgbe_pkg::REG_ORIGIN_X:     cfg_r.origin_x     <= cfg_wdata;
        sgbe_pkg::REG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_wdata;
        sgbe_pkg::REG_GLYPH_WIDTH:  cfg_r.glyph_width  <= cfg_wdata[7:0];
        sgbe_pkg::REG_GLYPH_HEIGHT: cfg_r.glyph_height <= cfg_wdata[7:0];
        sgbe_pkg::REG_SCALE:        cfg_r.scale        <= cfg_wdata[7:0];
        sgbe_pkg::REG_DRAW_COLOR:   cfg_r.draw_color   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = q_status.full;
  assign accept  = in_push && !in_full;

  sgbe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .glyph_bits (in_glyph_bits),
    .first_byte (in_first_byte),
    .q_push     (q_push),
    .q_data     (q_push_data)
  );

  sgbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  sgbe_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_head           (q_head),
    .q_status         (q_status),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_fill_x       (out_fill_x),
    .out_fill_y       (out_fill_y),
    .out_fill_size    (out_fill_size),
    .out_fill_color   (out_fill_color),
    .out_last_of_byte (out_last_of_byte)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_status.full)
    else $error("queue push while full");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_status.empty)
    else $error("queue pop while empty");

  a_push_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_push_data.mask != 8'h00))
    else $error("queued byte carries no pixel");

endmodule

/* bench/glyph_fill_checker.sv */
// ----------------------------------------------------------------------------
// glyph_fill_checker
// Watches the byte, fill-command and register ports of the glyph expander.
// Keeps a shadow of the registers and of the glyph position. Turns every
// accepted byte into the square fill commands it should produce, and
// compares each command taken from the result port against the oldest one
// still outstanding.
// ----------------------------------------------------------------------------
module glyph_fill_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  logic [7:0]         in_glyph_bits,
  input  logic               in_first_byte,
  input  logic               out_empty,
  input  logic               out_pop,
  input  logic signed [17:0] out_fill_x,
  input  logic signed [17:0] out_fill_y,
  input  logic [7:0]         out_fill_size,
  input  logic [15:0]        out_fill_color,
  input  logic               out_last_of_byte,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  output int unsigned        mismatch_count,
  output int unsigned        pending_fills
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sgbe_pkg::coord_t x;
    sgbe_pkg::coord_t y;
    logic [7:0]       size;
    logic [15:0]      color;
    logic             last;
  } fill_cmd_t;

  fill_cmd_t        expected_fills[$];
  sgbe_pkg::cfg_t   shadow_cfg;
  logic [4:0]       byte_col;
  logic [7:0]       glyph_row;
  sgbe_pkg::coord_t row_y;
  sgbe_pkg::coord_t byte_x;

  initial mismatch_count = 0;
  initial pending_fills = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ns: fill command error: %s", $time, msg);
  endtask

  function automatic void restart_position();
    byte_col  = '0;
    glyph_row = '0;
    row_y     = {{2{shadow_cfg.origin_y[15]}}, shadow_cfg.origin_y};
    byte_x    = {{2{shadow_cfg.origin_x[15]}}, shadow_cfg.origin_x};
  endfunction

  function automatic void expand_glyph_byte(input logic [7:0] bits, input logic first);
    int        row_bytes;
    int        b;
    logic      held;
    fill_cmd_t cmd;
    if (first) begin
      restart_position();
    end
    if (glyph_row >= shadow_cfg.glyph_height) begin
      return;
    end
    row_bytes = (int'(shadow_cfg.glyph_width) + 7) >> 3;
    if (row_bytes == 0) begin
      row_bytes = 1;
    end
    held = 1'b0;
    cmd  = '0;
    for (b = 0; b < 8; b++) begin
      if (int'(byte_col) * 8 + b >= int'(shadow_cfg.glyph_width)) begin
        break;
      end
      if (bits[7-b]) begin
        if (held) begin
          expected_fills.push_back(cmd);
        end
        cmd.x     = byte_x + sgbe_pkg::coord_t'(b * int'(shadow_cfg.scale));
        cmd.y     = row_y;
        cmd.size  = shadow_cfg.scale;
        cmd.color = shadow_cfg.draw_color;
        cmd.last  = 1'b0;
        held      = 1'b1;
      end
    end
    if (held) begin
      cmd.last = 1'b1;
      expected_fills.push_back(cmd);
    end
    if (int'(byte_col) + 1 >= row_bytes) begin
      byte_col  = '0;
      glyph_row = glyph_row + 8'd1;
      row_y     = row_y + {10'b0, shadow_cfg.scale};
      byte_x    = {{2{shadow_cfg.origin_x[15]}}, shadow_cfg.origin_x};
    end else begin
      byte_col = byte_col + 5'd1;
      byte_x   = byte_x + {7'b0, shadow_cfg.scale, 3'b000};
    end
  endfunction

  task automatic check_fill();
    fill_cmd_t want;
    if (expected_fills.size() == 0) begin
      report_mismatch($sformatf("unexpected command x=%0d y=%0d", out_fill_x, out_fill_y));
      return;
    end
    want = expected_fills.pop_front();
    if (out_fill_x !== want.x) begin
      report_mismatch($sformatf("fill_x %0d, expected %0d", out_fill_x, want.x));
    end
    if (out_fill_y !== want.y) begin
      report_mismatch($sformatf("fill_y %0d, expected %0d", out_fill_y, want.y));
    end
    if (out_fill_size !== want.size) begin
      report_mismatch($sformatf("fill_size %0d, expected %0d", out_fill_size, want.size));
    end
    if (out_fill_color !== want.color) begin
      report_mismatch($sformatf("fill_color %h, expected %h", out_fill_color, want.color));
    end
    if (out_last_of_byte !== want.last) begin
      report_mismatch($sformatf("last_of_byte %b, expected %b", out_last_of_byte, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg.origin_x     = 16'sd0;
      shadow_cfg.origin_y     = 16'sd0;
      shadow_cfg.glyph_width  = 8'd8;
      shadow_cfg.glyph_height = 8'd8;
      shadow_cfg.scale        = 8'd1;
      shadow_cfg.draw_color   = 16'hFFFF;
      restart_position();
      expected_fills.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          sgbe_pkg::REG_ORIGIN_X:     shadow_cfg.origin_x     = cfg_wdata;
          sgbe_pkg::REG_ORIGIN_Y:     shadow_cfg.origin_y     = cfg_wdata;
          sgbe_pkg::REG_GLYPH_WIDTH:  shadow_cfg.glyph_width  = cfg_wdata[7:0];
          sgbe_pkg::REG_GLYPH_HEIGHT: shadow_cfg.glyph_height = cfg_wdata[7:0];
          sgbe_pkg::REG_SCALE:        shadow_cfg.scale        = cfg_wdata[7:0];
          sgbe_pkg::REG_DRAW_COLOR:   shadow_cfg.draw_color   = cfg_wdata;
          default: ;
        endcase
      end
      if (out_pop && !out_empty) begin
        check_fill();
      end
      if (in_push && !in_full) begin
        expand_glyph_byte(in_glyph_bits, in_first_byte);
      end
    end
    pending_fills <= expected_fills.size();
  end

endmodule

/* bench/scaled_glyph_bitmap_expander_unit_tb.sv */
// ----------------------------------------------------------------------------
// scaled_glyph_bitmap_expander_unit_tb
// Drives glyph bytes and register setups into the expander and pops its
// fill commands. A directed part covers extreme origins and sizes, padding
// bits, bytes past the glyph, restarts, zero width, height and scale, and
// registers changed in the middle of a glyph. Random glyphs follow under
// changing setups and pacing, including a long result hold-off that backs
// the block up. Checking is done by glyph_fill_checker.
// ----------------------------------------------------------------------------
module scaled_glyph_bitmap_expander_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HoldCycles = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [7:0]         in_glyph_bits = 8'h00;
  logic               in_first_byte = 1'b0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [17:0] out_fill_x;
  logic signed [17:0] out_fill_y;
  logic [7:0]         out_fill_size;
  logic [15:0]        out_fill_color;
  logic               out_last_of_byte;
  logic               cfg_wr_en = 1'b0;
  logic [2:0]         cfg_index = sgbe_pkg::REG_ORIGIN_X;
  logic [15:0]        cfg_wdata = 16'h0000;

  int unsigned    mismatch_count;
  int unsigned    pending_fills;
  int unsigned    send_idle_pct = 0;
  int unsigned    pop_stall_pct = 0;
  logic           holding = 1'b0;
  sgbe_pkg::cfg_t setup;
  event           hold_go;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  scaled_glyph_bitmap_expander_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_glyph_bits    (in_glyph_bits),
    .in_first_byte    (in_first_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_fill_x       (out_fill_x),
    .out_fill_y       (out_fill_y),
    .out_fill_size    (out_fill_size),
    .out_fill_color   (out_fill_color),
    .out_last_of_byte (out_last_of_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  glyph_fill_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_glyph_bits    (in_glyph_bits),
    .in_first_byte    (in_first_byte),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_fill_x       (out_fill_x),
    .out_fill_y       (out_fill_y),
    .out_fill_size    (out_fill_size),
    .out_fill_color   (out_fill_color),
    .out_last_of_byte (out_last_of_byte),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .pending_fills    (pending_fills)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      out_pop <= !holding && ($urandom_range(99) >= pop_stall_pct);
    end
  end

  // hold the result port off for a fixed stretch
  always begin
    @(hold_go);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin
    #4ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic sgbe_pkg::cfg_t make_setup(input int ox, input int oy, input int w,
                                                input int h, input int sc, input int color);
    sgbe_pkg::cfg_t st;
    st.origin_x     = 16'(ox);
    st.origin_y     = 16'(oy);
    st.glyph_width  = 8'(w);
    st.glyph_height = 8'(h);
    st.scale        = 8'(sc);
    st.draw_color   = 16'(color);
    return st;
  endfunction

  function automatic logic [15:0] random_origin();
    case ($urandom_range(9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sgbe_pkg::cfg_t random_setup();
    sgbe_pkg::cfg_t st;
    int             pick;
    st.origin_x   = random_origin();
    st.origin_y   = random_origin();
    st.draw_color = 16'($urandom);
    pick = $urandom_range(9);
    if (pick < 7) begin
      st.glyph_width = 8'($urandom_range(1, 16));
    end else if (pick < 9) begin
      st.glyph_width = 8'($urandom_range(17, 64));
    end else begin
      st.glyph_width = 8'($urandom_range(65, 255));
    end
    if (st.glyph_width > 64) begin
      st.glyph_height = 8'($urandom_range(1, 2));
    end else if ($urandom_range(7) == 0) begin
      st.glyph_height = 8'($urandom_range(7, 255));
    end else begin
      st.glyph_height = 8'($urandom_range(1, 6));
    end
    case ($urandom_range(7))
      0: st.scale = 8'd1;
      1: st.scale = 8'd255;
      default: st.scale = 8'($urandom_range(1, 255));
    endcase
    return st;
  endfunction

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending_fills != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_setup(input sgbe_pkg::cfg_t st);
    logic [2:0]  idx [6];
    logic [15:0] val [6];
    wait_drained();
    idx = '{sgbe_pkg::REG_ORIGIN_X, sgbe_pkg::REG_ORIGIN_Y, sgbe_pkg::REG_GLYPH_WIDTH,
            sgbe_pkg::REG_GLYPH_HEIGHT, sgbe_pkg::REG_SCALE, sgbe_pkg::REG_DRAW_COLOR};
    val = '{st.origin_x, st.origin_y, {8'h00, st.glyph_width}, {8'h00, st.glyph_height},
            {8'h00, st.scale}, st.draw_color};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    setup = st;
  endtask

  task automatic send_glyph_byte(input logic [7:0] bits, input logic first);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push       <= 1'b1;
    in_glyph_bits <= bits;
    in_first_byte <= first;
    do @(posedge clk); while (in_full);
  endtask

  task automatic set_pacing(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  pop_stall_pct <= 0;  end
      1: begin send_idle_pct = 65; pop_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  pop_stall_pct <= 65; end
      default: begin send_idle_pct = 16; pop_stall_pct <= 16; end
    endcase
  endtask

  function automatic logic [7:0] random_bits();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // whole glyphs with random content, some cut short, some with trailing
  // bytes past the glyph and the odd stray restart
  task automatic send_glyphs(input int target);
    int sent;
    int row_bytes;
    int n_glyph;
    int n_tail;
    sent = 0;
    while (sent < target) begin
      row_bytes = (int'(setup.glyph_width) + 7) >> 3;
      if (row_bytes == 0) begin
        row_bytes = 1;
      end
      n_glyph = row_bytes * int'(setup.glyph_height);
      if (n_glyph > 60 || $urandom_range(9) == 0) begin
        n_glyph = $urandom_range(1, (n_glyph > 60) ? 60 : n_glyph);
      end
      n_tail = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < n_glyph + n_tail; i++) begin
        send_glyph_byte(random_bits(), (i == 0) || ($urandom_range(49) == 0));
        if (i < n_glyph) begin
          sent++;
        end
      end
    end
  endtask

  initial begin
    sgbe_pkg::cfg_t st;
    setup = make_setup(0, 0, 8, 8, 1, 16'hFFFF);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setup: full 8x8 glyph, then one byte past the glyph
    send_glyph_byte(8'hFF, 1'b1);
    send_glyph_byte(8'h00, 1'b0);
    send_glyph_byte(8'h80, 1'b0);
    send_glyph_byte(8'h01, 1'b0);
    send_glyph_byte(8'hA5, 1'b0);
    send_glyph_byte(8'h5A, 1'b0);
    send_glyph_byte(8'h7E, 1'b0);
    send_glyph_byte(8'h81, 1'b0);
    send_glyph_byte(8'hFF, 1'b0);

    // extreme origins and scale, padding-only byte, restart
    program_setup(make_setup(16'h8000, 16'h7FFF, 3, 2, 255, 0));
    send_glyph_byte(8'hFF, 1'b1);
    send_glyph_byte(8'h1F, 1'b0);
    send_glyph_byte(8'hE0, 1'b1);
    send_glyph_byte(8'h40, 1'b0);

    program_setup(make_setup(16'h7FFF, 16'h8000, 12, 3, 2, 16'h1234));
    send_glyph_byte(8'hFF, 1'b1);
    send_glyph_byte(8'hFF, 1'b0);
    send_glyph_byte(8'h0F, 1'b0);
    send_glyph_byte(8'hC3, 1'b1);
    send_glyph_byte(8'h80, 1'b0);

    // zero width, zero height, zero scale
    program_setup(make_setup(0, 0, 0, 4, 0, 16'hABCD));
    send_glyph_byte(8'hFF, 1'b1);
    send_glyph_byte(8'hFF, 1'b0);
    program_setup(make_setup(0, 0, 8, 0, 7, 0));
    send_glyph_byte(8'hFF, 1'b1);
    program_setup(make_setup(100, -5, 9, 2, 0, 16'h5555));
    send_glyph_byte(8'hFF, 1'b1);
    send_glyph_byte(8'h80, 1'b0);

    // narrow the row and move origin_x in the middle of a glyph
    program_setup(make_setup(10, 20, 24, 4, 3, 16'h0F0F));
    send_glyph_byte(8'hFF, 1'b1);
    send_glyph_byte(8'h81, 1'b0);
    program_setup(make_setup(-40, 20, 8, 4, 3, 16'hF0F0));
    send_glyph_byte(8'hFF, 1'b0);
    send_glyph_byte(8'hFF, 1'b0);
    send_glyph_byte(8'h01, 1'b0);

    for (int p = 0; p < 10; p++) begin
      set_pacing(p % 4);
      st = random_setup();
      if (p == 9) begin
        st.glyph_width  = 8'd255;
        st.glyph_height = 8'd2;
        st.scale        = 8'd255;
      end
      program_setup(st);
      if (p == 4) begin
        -> hold_go;
      end
      send_glyphs(30);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/sgbe_pkg.sv
hw/rtl/sgbe_front.sv
hw/rtl/sgbe_queue.sv
hw/rtl/sgbe_back.sv
hw/rtl/scaled_glyph_bitmap_expander_unit.sv
bench/glyph_fill_checker.sv
bench/scaled_glyph_bitmap_expander_unit_tb.sv
